/* sv/cilp_pkg.sv */
// Shared types and character constants for the console integer line parser.
// Used by cilp_ctrl, cilp_dp and console_integer_line_parser_core; no dependencies.
package cilp_pkg;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CR_LF,
        ST_LF_LF,
        ST_BS_SPACE,
        ST_BS_BACK,
        ST_PARSE,
        ST_SUFFIX,
        ST_WALK,
        ST_NUMBER
    } cilp_state_t;

    // Phases of the decimal scan.
    typedef enum logic [1:0] {
        DEC_SKIP,
        DEC_DIGITS,
        DEC_STOP
    } cilp_dec_phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       store;        // write the received byte at the end of the line
        logic       backspace;    // drop the last stored character
        logic       clear;        // empty the line
        logic       out_load;     // load a result into the output register
        logic       out_kind;     // result kind: 0 echo, 1 number
        logic [7:0] out_byte;     // echo byte for an echo result
        logic       out_last;     // final result of the current item
        logic       parse_start;  // decode sign and prefix, read the last character
        logic       parse_empty;  // body is empty, result is minus one
        logic       parse_suffix; // check for a hex suffix, read the first body byte
        logic       walk;         // consume one body byte
    } cilp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic len_zero;   // line is empty
        logic len_full;   // line is full
        logic body_empty; // nothing left after sign and prefix
        logic walk_done;  // all body bytes consumed
    } cilp_status_t;

    // Character codes.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_H  = 8'h48;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_H  = 8'h68;
    localparam logic [7:0] CHAR_LO_X  = 8'h78;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;

    // Offsets that turn a letter or digit code into its hex value.
    localparam logic [31:0] HEX_UPPER_OFFSET = 32'd55;
    localparam logic [31:0] HEX_LOWER_OFFSET = 32'd87;
    localparam logic [31:0] HEX_DIGIT_OFFSET = 32'd48;

endpackage

/* sv/cilp_ctrl.sv */
// Controller state machine of the console integer line parser.
// Depends on cilp_pkg for the state type and the command and status structs.
module cilp_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    input  cilp_pkg::cilp_status_t st,
    output cilp_pkg::cilp_cmd_t    cmd
);

    cilp_pkg::cilp_state_t state_reg;
    cilp_pkg::cilp_state_t state_next;
    logic                  accept;

    // An input beat is taken only when idle and the output slot is free.
    assign in_stall = !((state_reg == cilp_pkg::ST_IDLE) && st.out_free);
    assign accept   = in_valid && !in_stall;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cilp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cilp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (rx_byte)
                        cilp_pkg::CHAR_NUL:
                        begin
                            state_next = cilp_pkg::ST_IDLE;
                        end
                        cilp_pkg::CHAR_CR:
                        begin
                            state_next = cilp_pkg::ST_CR_LF;
                        end
                        cilp_pkg::CHAR_BS:
                        begin
                            if (!st.len_zero)
                            begin
                                state_next = cilp_pkg::ST_BS_SPACE;
                            end
                        end
                        cilp_pkg::CHAR_LF:
                        begin
                            if (!st.len_full)
                            begin
                                state_next = cilp_pkg::ST_LF_LF;
                            end
                        end
                        default:
                        begin
                            state_next = cilp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            cilp_pkg::ST_CR_LF:
            begin
                if (st.out_free)
                begin
                    state_next = cilp_pkg::ST_PARSE;
                end
            end
            cilp_pkg::ST_LF_LF:
            begin
                if (st.out_free)
                begin
                    state_next = cilp_pkg::ST_IDLE;
                end
            end
            cilp_pkg::ST_BS_SPACE:
            begin
                if (st.out_free)
                begin
                    state_next = cilp_pkg::ST_BS_BACK;
                end
            end
            cilp_pkg::ST_BS_BACK:
            begin
                if (st.out_free)
                begin
                    state_next = cilp_pkg::ST_IDLE;
                end
            end
            cilp_pkg::ST_PARSE:
            begin
                if (st.body_empty)
                begin
                    state_next = cilp_pkg::ST_NUMBER;
                end
                else
                begin
                    state_next = cilp_pkg::ST_SUFFIX;
                end
            end
            cilp_pkg::ST_SUFFIX:
            begin
                state_next = cilp_pkg::ST_WALK;
            end
            cilp_pkg::ST_WALK:
            begin
                if (st.walk_done)
                begin
                    state_next = cilp_pkg::ST_NUMBER;
                end
            end
            cilp_pkg::ST_NUMBER:
            begin
                if (st.out_free)
                begin
                    state_next = cilp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cilp_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            cilp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (rx_byte)
                        cilp_pkg::CHAR_NUL:
                        begin
                            cmd = '0;
                        end
                        cilp_pkg::CHAR_CR:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_byte = cilp_pkg::CHAR_CR;
                        end
                        cilp_pkg::CHAR_BS:
                        begin
                            if (!st.len_zero)
                            begin
                                cmd.backspace = 1'b1;
                                cmd.out_load  = 1'b1;
                                cmd.out_byte  = cilp_pkg::CHAR_BS;
                            end
                        end
                        cilp_pkg::CHAR_LF:
                        begin
                            if (!st.len_full)
                            begin
                                cmd.store    = 1'b1;
                                cmd.out_load = 1'b1;
                                cmd.out_byte = cilp_pkg::CHAR_CR;
                            end
                        end
                        default:
                        begin
                            if (!st.len_full)
                            begin
                                cmd.store    = 1'b1;
                                cmd.out_load = 1'b1;
                                cmd.out_byte = rx_byte;
                                cmd.out_last = 1'b1;
                            end
                        end
                    endcase
                end
            end
            cilp_pkg::ST_CR_LF:
            begin
                cmd.out_load = st.out_free;
                cmd.out_byte = cilp_pkg::CHAR_LF;
            end
            cilp_pkg::ST_LF_LF:
            begin
                cmd.out_load = st.out_free;
                cmd.out_byte = cilp_pkg::CHAR_LF;
                cmd.out_last = 1'b1;
            end
            cilp_pkg::ST_BS_SPACE:
            begin
                cmd.out_load = st.out_free;
                cmd.out_byte = cilp_pkg::CHAR_SPACE;
            end
            cilp_pkg::ST_BS_BACK:
            begin
                cmd.out_load = st.out_free;
                cmd.out_byte = cilp_pkg::CHAR_BS;
                cmd.out_last = 1'b1;
            end
            cilp_pkg::ST_PARSE:
            begin
                cmd.parse_empty = st.body_empty;
                cmd.parse_start = !st.body_empty;
            end
            cilp_pkg::ST_SUFFIX:
            begin
                cmd.parse_suffix = 1'b1;
            end
            cilp_pkg::ST_WALK:
            begin
                cmd.walk = !st.walk_done;
            end
            cilp_pkg::ST_NUMBER:
            begin
                cmd.out_load = st.out_free;
                cmd.out_kind = 1'b1;
                cmd.out_last = 1'b1;
                cmd.clear    = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* sv/cilp_dp.sv */
// Datapath of the console integer line parser: line memory, parse accumulator
// and output register. Depends on cilp_pkg for the command and status structs.
module cilp_dp
#(
    parameter int LINE_DEPTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             rx_byte,
    input  cilp_pkg::cilp_cmd_t    cmd,
    output cilp_pkg::cilp_status_t st,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   kind,
    output logic [7:0]             tx_byte,
    output logic signed [31:0]     number,
    output logic                   last
);

    localparam int LW = $clog2(LINE_DEPTH + 1);
    localparam int AW = $clog2(LINE_DEPTH);

    // Line memory and the shadow copy of its first three characters.
    logic [7:0]    line_mem [LINE_DEPTH];
    logic [7:0]    head_reg [3];
    logic [7:0]    rd_data_reg;
    logic [LW-1:0] rd_addr;
    logic [AW-1:0] rd_idx;

    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;

    // Parse state.
    logic [LW-1:0]             pos_reg;
    logic [LW-1:0]             end_reg;
    logic [LW-1:0]             ptr_reg;
    logic [31:0]               acc_reg;
    logic                      hex_reg;
    logic                      minus_reg;
    logic                      neg_reg;
    cilp_pkg::cilp_dec_phase_t phase_reg;

    // Output register.
    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  out_tx_reg;
    logic [31:0] out_num_reg;
    logic        out_last_reg;

    logic          out_free;
    logic          minus_c;
    logic          prefix_c;
    logic [7:0]    pfx_first;
    logic [7:0]    pfx_second;
    logic [LW-1:0] start_c;
    logic          is_suffix;
    logic [7:0]    c;
    logic          c_upper;
    logic          c_lower;
    logic          c_digit;
    logic          c_space;
    logic [31:0]   hex_v;
    logic [31:0]   acc_hex;
    logic [31:0]   acc_dec;
    logic [31:0]   result;

    assign out_free = !out_valid_reg || !out_stall;

    // Sign and hex prefix, decoded from the shadowed head of the line.
    always_comb
    begin
        minus_c    = (len_reg != '0) && (head_reg[0] == cilp_pkg::CHAR_MINUS);
        pfx_first  = minus_c ? head_reg[1] : head_reg[0];
        pfx_second = minus_c ? head_reg[2] : head_reg[1];
        prefix_c   = (len_reg > (minus_c ? LW'(2) : LW'(1))) &&
                     (pfx_first == cilp_pkg::CHAR_ZERO) &&
                     ((pfx_second == cilp_pkg::CHAR_LO_X) ||
                      (pfx_second == cilp_pkg::CHAR_UP_X));
        start_c    = LW'(minus_c) + (prefix_c ? LW'(2) : LW'(0));
    end

    // Classification of the byte under the read pointer.
    always_comb
    begin
        c       = rd_data_reg;
        c_upper = (c >= cilp_pkg::CHAR_UP_A) && (c <= cilp_pkg::CHAR_UP_Z);
        c_lower = (c >= cilp_pkg::CHAR_LO_A) && (c <= cilp_pkg::CHAR_LO_Z);
        c_digit = (c >= cilp_pkg::CHAR_ZERO) && (c <= cilp_pkg::CHAR_NINE);
        c_space = (c == cilp_pkg::CHAR_SPACE) ||
                  ((c >= cilp_pkg::CHAR_TAB) && (c <= cilp_pkg::CHAR_CR));
        is_suffix = (c == cilp_pkg::CHAR_LO_H) || (c == cilp_pkg::CHAR_UP_H);
        if (c_upper)
        begin
            hex_v = {24'd0, c} - cilp_pkg::HEX_UPPER_OFFSET;
        end
        else if (c_lower)
        begin
            hex_v = {24'd0, c} - cilp_pkg::HEX_LOWER_OFFSET;
        end
        else
        begin
            hex_v = {24'd0, c} - cilp_pkg::HEX_DIGIT_OFFSET;
        end
        acc_hex = {acc_reg[27:0], 4'd0} + hex_v;
        acc_dec = {acc_reg[28:0], 3'd0} + {acc_reg[30:0], 1'b0} +
                  {28'd0, c[3:0]};
        result  = (neg_reg ^ minus_reg) ? (32'd0 - acc_reg) : acc_reg;
    end

    // Read address: last character, first body byte, or the next body byte.
    always_comb
    begin
        if (cmd.parse_start)
        begin
            rd_addr = len_reg - LW'(1);
        end
        else if (cmd.parse_suffix)
        begin
            rd_addr = pos_reg;
        end
        else
        begin
            rd_addr = ptr_reg + LW'(1);
        end
        rd_idx = (rd_addr < LW'(LINE_DEPTH)) ? rd_addr[AW-1:0] : '0;
    end

    // Line length.
    always_comb
    begin
        len_next = len_reg;
        if (cmd.clear)
        begin
            len_next = '0;
        end
        else if (cmd.store)
        begin
            len_next = len_reg + LW'(1);
        end
        else if (cmd.backspace)
        begin
            len_next = len_reg - LW'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Line memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            line_mem[len_reg[AW-1:0]] <= rx_byte;
        end
        rd_data_reg <= line_mem[rd_idx];
    end

    // Shadow of the first three characters for the sign and prefix check.
    always_ff @(posedge clk)
    begin
        if (cmd.store && (len_reg < LW'(3)))
        begin
            head_reg[len_reg[1:0]] <= rx_byte;
        end
    end

    // Parse sequencing and accumulation.
    always_ff @(posedge clk)
    begin
        if (cmd.parse_empty)
        begin
            acc_reg   <= '1;
            neg_reg   <= 1'b0;
            minus_reg <= 1'b0;
            hex_reg   <= 1'b1;
            phase_reg <= cilp_pkg::DEC_STOP;
        end
        else if (cmd.parse_start)
        begin
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            minus_reg <= minus_c;
            hex_reg   <= prefix_c;
            phase_reg <= cilp_pkg::DEC_SKIP;
            pos_reg   <= start_c;
            end_reg   <= len_reg;
        end
        else if (cmd.parse_suffix)
        begin
            ptr_reg <= pos_reg;
            if (is_suffix)
            begin
                hex_reg <= 1'b1;
                end_reg <= end_reg - LW'(1);
            end
        end
        else if (cmd.walk)
        begin
            ptr_reg <= ptr_reg + LW'(1);
            if (hex_reg)
            begin
                acc_reg <= acc_hex;
            end
            else
            begin
                case (phase_reg)
                    cilp_pkg::DEC_SKIP:
                    begin
                        if (c_space)
                        begin
                            phase_reg <= cilp_pkg::DEC_SKIP;
                        end
                        else if ((c == cilp_pkg::CHAR_PLUS) ||
                                 (c == cilp_pkg::CHAR_MINUS))
                        begin
                            neg_reg   <= (c == cilp_pkg::CHAR_MINUS);
                            phase_reg <= cilp_pkg::DEC_DIGITS;
                        end
                        else if (c_digit)
                        begin
                            acc_reg   <= acc_dec;
                            phase_reg <= cilp_pkg::DEC_DIGITS;
                        end
                        else
                        begin
                            phase_reg <= cilp_pkg::DEC_STOP;
                        end
                    end
                    cilp_pkg::DEC_DIGITS:
                    begin
                        if (c_digit)
                        begin
                            acc_reg <= acc_dec;
                        end
                        else
                        begin
                            phase_reg <= cilp_pkg::DEC_STOP;
                        end
                    end
                    default:
                    begin
                        phase_reg <= cilp_pkg::DEC_STOP;
                    end
                endcase
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.out_kind;
            out_tx_reg   <= cmd.out_kind ? 8'd0 : cmd.out_byte;
            out_num_reg  <= cmd.out_kind ? result : 32'd0;
            out_last_reg <= cmd.out_last;
        end
    end

    // Status to the controller.
    always_comb
    begin
        st.out_free   = out_free;
        st.len_zero   = (len_reg == '0);
        st.len_full   = (len_reg == LW'(LINE_DEPTH));
        st.body_empty = (len_reg == start_c);
        st.walk_done  = (ptr_reg == end_reg);
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign tx_byte   = out_tx_reg;
    assign number    = out_num_reg;
    assign last      = out_last_reg;

endmodule

/* sv/console_integer_line_parser_core.sv */
// A stored character is echoed in the cycle after its beat; backspace and
// line feed give one echo beat per cycle while the output is not stalled.
// Carriage return: two echo beats, then the number, after the parse, the suffix check
// and the walk over the line memory, one byte a cycle. The next input byte is taken
// only once the controller is idle again and the output slot is free. Reset
// (rst_n, asynchronous, active low) empties the line and the output register.
module console_integer_line_parser_core
#(
    parameter int LINE_DEPTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [7:0]         tx_byte,
    output logic signed [31:0] number,
    output logic               last
);

    cilp_pkg::cilp_cmd_t    cmd;
    cilp_pkg::cilp_status_t st;

    // Controller.
    cilp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath.
    cilp_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx_byte),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .tx_byte   (tx_byte),
        .number    (number),
        .last      (last)
    );

    // A number beat always closes its item.
    a_number_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind) |-> last)
        else $error("number beat without last");

    // An input beat is never taken while a result waits stalled.
    a_accept_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !(out_valid && out_stall))
        else $error("input accepted while output is blocked");

    // The line is never written past its capacity.
    a_store_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !st.len_full)
        else $error("store into a full line");

    // Backspace never acts on an empty line.
    a_backspace_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.backspace |-> !st.len_zero)
        else $error("backspace on an empty line");

endmodule
